>>> rtl/segment_intersection_defines.svh
// Assertion macros used by the segment intersection top level.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// Checks that a condition in the same cycle implies a consequence.
`define SGI_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("segment_intersection: same-cycle check failed");

// Checks that a condition implies a consequence in the next cycle.
`define SGI_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("segment_intersection: next-cycle check failed");

`endif

>>> rtl/sgi_pkg.sv
// Package with the default sizes and pipeline latencies of the segment intersection block.
package sgi_pkg;

    localparam int SGI_COORD_BITS = 24;
    localparam int SGI_FRAC_BITS  = 8;
    localparam int SGI_NUDGE_LSB  = 3;

    // Register stages in the front end and in the numerator section.
    localparam int SGI_FRONT_LAT  = 3;
    localparam int SGI_NUMER_LAT  = 4;
    // Stages after the dividers: sign and range fix, then box test and output.
    localparam int SGI_BACK_LAT   = 2;

endpackage

>>> rtl/segment_intersection.sv
// Top level of the pipelined line segment intersection block.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | start, busy       | seg_a_start_x .. seg_b_end_y (signed)
//  result   | done (strobe)     | cross_x, cross_y (signed), hit
//
//  One transfer is accepted in every cycle in which start is high; busy stays low.
//  Each transfer gives one result, after the bit-per-stage dividers (COORD_BITS stages)
//  plus nine arithmetic and check stages.
//  Reset clears the valid bits of every stage, so no result appears from stale data.
//  The result strobe cannot be held off, so the pipeline never stalls.
module segment_intersection #(
    parameter int COORD_BITS = sgi_pkg::SGI_COORD_BITS,
    parameter int FRAC_BITS  = sgi_pkg::SGI_FRAC_BITS,
    parameter int NUDGE_LSB  = sgi_pkg::SGI_NUDGE_LSB
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] seg_a_start_x,
    input  logic signed [COORD_BITS-1:0] seg_a_start_y,
    input  logic signed [COORD_BITS-1:0] seg_a_end_x,
    input  logic signed [COORD_BITS-1:0] seg_a_end_y,
    input  logic signed [COORD_BITS-1:0] seg_b_start_x,
    input  logic signed [COORD_BITS-1:0] seg_b_start_y,
    input  logic signed [COORD_BITS-1:0] seg_b_end_x,
    input  logic signed [COORD_BITS-1:0] seg_b_end_y,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y,
    output logic                         hit
);
    import sgi_pkg::*;

`include "segment_intersection_defines.svh"

    localparam int N         = COORD_BITS;
    localparam int NW        = N + 1;
    localparam int DW        = N + 2;
    localparam int CW        = 2 * NW + 1;
    localparam int DENW      = 2 * DW + 1;
    localparam int NUMW      = 3 * N + 6;
    localparam int SIDE_DLY  = SGI_NUMER_LAT + N;
    localparam int TOTAL_LAT = SGI_FRONT_LAT + SIDE_DLY + SGI_BACK_LAT;
    localparam logic signed [N-1:0] MISS = N'(-(longint'(1) << FRAC_BITS));
    localparam logic [N-1:0]        NEG_LIMIT = N'(1) << (N - 1);

    // The pipeline never pushes back.
    assign busy = 1'b0;

    // Front end: nudge, cross products, denominator.
    logic                   fr_valid;
    logic signed [CW-1:0]   fr_c12, fr_c34;
    logic signed [DENW-1:0] fr_den;
    logic signed [DW-1:0]   fr_dx12, fr_dy12, fr_dx34, fr_dy34;
    logic [8*NW-1:0]        fr_bounds;

    sgi_front #(
        .COORD_BITS (COORD_BITS),
        .NUDGE_LSB  (NUDGE_LSB)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .ax1       (seg_a_start_x),
        .ay1       (seg_a_start_y),
        .ax2       (seg_a_end_x),
        .ay2       (seg_a_end_y),
        .bx1       (seg_b_start_x),
        .by1       (seg_b_start_y),
        .bx2       (seg_b_end_x),
        .by2       (seg_b_end_y),
        .valid_out (fr_valid),
        .c12       (fr_c12),
        .c34       (fr_c34),
        .den       (fr_den),
        .dx12      (fr_dx12),
        .dy12      (fr_dy12),
        .dx34      (fr_dx34),
        .dy34      (fr_dy34),
        .bounds    (fr_bounds)
    );

    // Numerators in sign-magnitude form for the dividers.
    logic            nm_valid;
    logic [NUMW-1:0] nm_x_mag, nm_y_mag;
    logic [DENW-1:0] nm_den_mag;
    logic            nm_neg_x, nm_neg_y;

    sgi_numer #(
        .COORD_BITS (COORD_BITS)
    ) u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (fr_valid),
        .c12       (fr_c12),
        .c34       (fr_c34),
        .den       (fr_den),
        .dx12      (fr_dx12),
        .dy12      (fr_dy12),
        .dx34      (fr_dx34),
        .dy34      (fr_dy34),
        .valid_out (nm_valid),
        .num_x_mag (nm_x_mag),
        .num_y_mag (nm_y_mag),
        .den_mag   (nm_den_mag),
        .neg_x     (nm_neg_x),
        .neg_y     (nm_neg_y)
    );

    // One divider per coordinate; both see the same divisor and run in lockstep.
    logic         dx_valid, dy_valid;
    logic [N-1:0] dx_mag, dy_mag;
    logic         dx_ovf, dy_ovf, dx_neg, dy_neg;

    sgi_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (nm_valid),
        .num_mag   (nm_x_mag),
        .den_mag   (nm_den_mag),
        .neg_in    (nm_neg_x),
        .valid_out (dx_valid),
        .quo_mag   (dx_mag),
        .ovf       (dx_ovf),
        .neg_out   (dx_neg)
    );

    sgi_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (nm_valid),
        .num_mag   (nm_y_mag),
        .den_mag   (nm_den_mag),
        .neg_in    (nm_neg_y),
        .valid_out (dy_valid),
        .quo_mag   (dy_mag),
        .ovf       (dy_ovf),
        .neg_out   (dy_neg)
    );

    // The bounding boxes ride alongside the numerator and divider stages.
    logic [8*NW-1:0] side_reg [SIDE_DLY];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= fr_bounds;
        for (int i = 1; i < SIDE_DLY; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // First back stage: apply the quotient sign and check the coordinate range.
    // A negative quotient may reach magnitude 2**(N-1); a positive one stays below it.
    logic signed [N-1:0] qx_reg, qy_reg;
    logic                fit_reg;
    logic [8*NW-1:0]     box_reg;
    logic                vq_reg;
    logic                fit_x, fit_y;

    assign fit_x = !dx_ovf && (dx_neg ? (dx_mag <= NEG_LIMIT) : !dx_mag[N-1]);
    assign fit_y = !dy_ovf && (dy_neg ? (dy_mag <= NEG_LIMIT) : !dy_mag[N-1]);

    always_ff @(posedge clk)
    begin
        qx_reg  <= dx_neg ? N'(-dx_mag) : dx_mag;
        qy_reg  <= dy_neg ? N'(-dy_mag) : dy_mag;
        fit_reg <= fit_x && fit_y;
        box_reg <= side_reg[SIDE_DLY-1];
    end

    // Second back stage: inclusive bounding-box test on both segments.
    logic signed [NW-1:0] ax_lo, ax_hi, ay_lo, ay_hi, bx_lo, bx_hi, by_lo, by_hi;
    logic signed [NW-1:0] px, py;
    logic                 hit_next;

    assign {ax_lo, ax_hi, ay_lo, ay_hi, bx_lo, bx_hi, by_lo, by_hi} = box_reg;
    assign px = NW'(qx_reg);
    assign py = NW'(qy_reg);

    assign hit_next = fit_reg &&
                      (px >= ax_lo) && (px <= ax_hi) && (py >= ay_lo) && (py <= ay_hi) &&
                      (px >= bx_lo) && (px <= bx_hi) && (py >= by_lo) && (py <= by_hi);

    logic signed [N-1:0] cross_x_reg, cross_y_reg;
    logic                hit_reg;
    logic                done_reg;

    always_ff @(posedge clk)
    begin
        cross_x_reg <= hit_next ? qx_reg : MISS;
        cross_y_reg <= hit_next ? qy_reg : MISS;
        hit_reg     <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vq_reg   <= dx_valid;
            done_reg <= vq_reg;
        end
    end

    assign done    = done_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;
    assign hit     = hit_reg;

    // The two dividers must stay in lockstep.
    `SGI_ASSERT_NOW(a_div_lockstep, 1'b1, dx_valid == dy_valid)
    // A result strobe is always the answer to a transfer a fixed time earlier.
    `SGI_ASSERT_NOW(a_fixed_latency, done, $past(start, TOTAL_LAT))
    // A miss always reports the marker point.
    `SGI_ASSERT_NOW(a_miss_marker, done && !hit, cross_x == MISS && cross_y == MISS)
    // A hit in the box stage must come from an in-range quotient.
    `SGI_ASSERT_NEXT(a_hit_needs_fit, vq_reg && !fit_reg, !hit)

endmodule

>>> rtl/sgi_front.sv
// Front end: endpoint nudge, differences, cross products and the denominator.
module sgi_front #(
    parameter int COORD_BITS = sgi_pkg::SGI_COORD_BITS,
    parameter int NUDGE_LSB  = sgi_pkg::SGI_NUDGE_LSB
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic signed [COORD_BITS-1:0]  ax1,
    input  logic signed [COORD_BITS-1:0]  ay1,
    input  logic signed [COORD_BITS-1:0]  ax2,
    input  logic signed [COORD_BITS-1:0]  ay2,
    input  logic signed [COORD_BITS-1:0]  bx1,
    input  logic signed [COORD_BITS-1:0]  by1,
    input  logic signed [COORD_BITS-1:0]  bx2,
    input  logic signed [COORD_BITS-1:0]  by2,
    output logic                          valid_out,
    output logic signed [2*COORD_BITS+2:0] c12,
    output logic signed [2*COORD_BITS+2:0] c34,
    output logic signed [2*COORD_BITS+4:0] den,
    output logic signed [COORD_BITS+1:0]  dx12,
    output logic signed [COORD_BITS+1:0]  dy12,
    output logic signed [COORD_BITS+1:0]  dx34,
    output logic signed [COORD_BITS+1:0]  dy34,
    output logic [8*(COORD_BITS+1)-1:0]   bounds
);
    import sgi_pkg::*;

    localparam int NW   = COORD_BITS + 1;
    localparam int DW   = COORD_BITS + 2;
    localparam int CW   = 2 * NW + 1;
    localparam int DENW = 2 * DW + 1;
    localparam logic signed [NW-1:0] NUDGE = NW'(NUDGE_LSB);

    // Stage 1: nudged endpoints and differences.
    logic signed [NW-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic signed [NW-1:0] x1_next, y1_next, x3_next, y3_next;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d3x_reg, d3y_reg;
    logic                 v1_reg;

    always_comb
    begin
        x1_next = (ax1 == ax2) ? NW'(ax1) + NUDGE : NW'(ax1);
        y1_next = (ay1 == ay2) ? NW'(ay1) + NUDGE : NW'(ay1);
        x3_next = (bx1 == bx2) ? NW'(bx1) + NUDGE : NW'(bx1);
        y3_next = (by1 == by2) ? NW'(by1) + NUDGE : NW'(by1);
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= x1_next;
        y1_reg  <= y1_next;
        x2_reg  <= NW'(ax2);
        y2_reg  <= NW'(ay2);
        x3_reg  <= x3_next;
        y3_reg  <= y3_next;
        x4_reg  <= NW'(bx2);
        y4_reg  <= NW'(by2);
        d1x_reg <= DW'(x1_next) - DW'(ax2);
        d1y_reg <= DW'(y1_next) - DW'(ay2);
        d3x_reg <= DW'(x3_next) - DW'(bx2);
        d3y_reg <= DW'(y3_next) - DW'(by2);
    end

    // Stage 2: the six products and the bounding boxes.
    logic signed [2*NW-1:0] p_x1y2_reg, p_y1x2_reg, p_x3y4_reg, p_y3x4_reg;
    logic signed [2*DW-1:0] p_den_a_reg, p_den_b_reg;
    logic signed [DW-1:0]   e1x_reg, e1y_reg, e3x_reg, e3y_reg;
    logic [8*NW-1:0]        box2_reg;
    logic                   v2_reg;

    always_ff @(posedge clk)
    begin
        p_x1y2_reg  <= x1_reg * y2_reg;
        p_y1x2_reg  <= y1_reg * x2_reg;
        p_x3y4_reg  <= x3_reg * y4_reg;
        p_y3x4_reg  <= y3_reg * x4_reg;
        p_den_a_reg <= d1x_reg * d3y_reg;
        p_den_b_reg <= d1y_reg * d3x_reg;
        e1x_reg     <= d1x_reg;
        e1y_reg     <= d1y_reg;
        e3x_reg     <= d3x_reg;
        e3y_reg     <= d3y_reg;
        // Low bound then high bound for segment A x, A y, B x, B y.
        box2_reg <= {
            (x1_reg < x2_reg) ? x1_reg : x2_reg, (x1_reg < x2_reg) ? x2_reg : x1_reg,
            (y1_reg < y2_reg) ? y1_reg : y2_reg, (y1_reg < y2_reg) ? y2_reg : y1_reg,
            (x3_reg < x4_reg) ? x3_reg : x4_reg, (x3_reg < x4_reg) ? x4_reg : x3_reg,
            (y3_reg < y4_reg) ? y3_reg : y4_reg, (y3_reg < y4_reg) ? y4_reg : y3_reg};
    end

    // Stage 3: line constants and the denominator.
    logic signed [CW-1:0]   c12_reg, c34_reg;
    logic signed [DENW-1:0] den_reg;
    logic signed [DW-1:0]   f1x_reg, f1y_reg, f3x_reg, f3y_reg;
    logic [8*NW-1:0]        box3_reg;
    logic                   v3_reg;

    always_ff @(posedge clk)
    begin
        c12_reg  <= CW'(p_x1y2_reg) - CW'(p_y1x2_reg);
        c34_reg  <= CW'(p_x3y4_reg) - CW'(p_y3x4_reg);
        den_reg  <= DENW'(p_den_a_reg) - DENW'(p_den_b_reg);
        f1x_reg  <= e1x_reg;
        f1y_reg  <= e1y_reg;
        f3x_reg  <= e3x_reg;
        f3y_reg  <= e3y_reg;
        box3_reg <= box2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign c12       = c12_reg;
    assign c34       = c34_reg;
    assign den       = den_reg;
    assign dx12      = f1x_reg;
    assign dy12      = f1y_reg;
    assign dx34      = f3x_reg;
    assign dy34      = f3y_reg;
    assign bounds    = box3_reg;

endmodule

>>> rtl/sgi_numer.sv
// Numerator section: split wide products, numerators, and sign-magnitude conversion.
module sgi_numer #(
    parameter int COORD_BITS = sgi_pkg::SGI_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [2*COORD_BITS+2:0] c12,
    input  logic signed [2*COORD_BITS+2:0] c34,
    input  logic signed [2*COORD_BITS+4:0] den,
    input  logic signed [COORD_BITS+1:0]   dx12,
    input  logic signed [COORD_BITS+1:0]   dy12,
    input  logic signed [COORD_BITS+1:0]   dx34,
    input  logic signed [COORD_BITS+1:0]   dy34,
    output logic                           valid_out,
    output logic [3*COORD_BITS+5:0]        num_x_mag,
    output logic [3*COORD_BITS+5:0]        num_y_mag,
    output logic [2*COORD_BITS+4:0]        den_mag,
    output logic                           neg_x,
    output logic                           neg_y
);
    import sgi_pkg::*;

    localparam int DW   = COORD_BITS + 2;
    localparam int CW   = 2 * COORD_BITS + 3;
    localparam int DENW = 2 * DW + 1;
    localparam int L    = CW / 2;
    localparam int PLW  = L + 1 + DW;
    localparam int PHW  = CW - L + DW;
    localparam int PW   = CW + DW;
    localparam int NUMW = PW + 1;

    // Low halves of the line constants as nonnegative signed operands.
    logic signed [L:0]      c12_lo, c34_lo;
    logic signed [CW-L-1:0] c12_hi, c34_hi;

    assign c12_lo = $signed({1'b0, c12[L-1:0]});
    assign c34_lo = $signed({1'b0, c34[L-1:0]});
    assign c12_hi = c12[CW-1:L];
    assign c34_hi = c34[CW-1:L];

    // Stage 4: partial products.
    logic signed [PLW-1:0]  ax_lo_reg, ay_lo_reg, bx_lo_reg, by_lo_reg;
    logic signed [PHW-1:0]  ax_hi_reg, ay_hi_reg, bx_hi_reg, by_hi_reg;
    logic signed [DENW-1:0] den4_reg;
    logic                   v4_reg;

    always_ff @(posedge clk)
    begin
        ax_lo_reg <= c12_lo * dx34;
        ax_hi_reg <= c12_hi * dx34;
        bx_lo_reg <= c34_lo * dx12;
        bx_hi_reg <= c34_hi * dx12;
        ay_lo_reg <= c12_lo * dy34;
        ay_hi_reg <= c12_hi * dy34;
        by_lo_reg <= c34_lo * dy12;
        by_hi_reg <= c34_hi * dy12;
        den4_reg  <= den;
    end

    // Stage 5: full products from the partial products.
    logic signed [PW-1:0]   ax_reg, bx_reg, ay_reg, by_reg;
    logic signed [DENW-1:0] den5_reg;
    logic                   v5_reg;

    always_ff @(posedge clk)
    begin
        ax_reg   <= (PW'(ax_hi_reg) <<< L) + PW'(ax_lo_reg);
        bx_reg   <= (PW'(bx_hi_reg) <<< L) + PW'(bx_lo_reg);
        ay_reg   <= (PW'(ay_hi_reg) <<< L) + PW'(ay_lo_reg);
        by_reg   <= (PW'(by_hi_reg) <<< L) + PW'(by_lo_reg);
        den5_reg <= den4_reg;
    end

    // Stage 6: numerators.
    logic signed [NUMW-1:0] nx_reg, ny_reg;
    logic signed [DENW-1:0] den6_reg;
    logic                   v6_reg;

    always_ff @(posedge clk)
    begin
        nx_reg   <= NUMW'(ax_reg) - NUMW'(bx_reg);
        ny_reg   <= NUMW'(ay_reg) - NUMW'(by_reg);
        den6_reg <= den5_reg;
    end

    // Stage 7: magnitudes and quotient signs.
    logic [NUMW-1:0] nx_mag_reg, ny_mag_reg;
    logic [DENW-1:0] den_mag_reg;
    logic            neg_x_reg, neg_y_reg;
    logic            v7_reg;
    logic            den_neg;

    assign den_neg = den6_reg[DENW-1];

    always_ff @(posedge clk)
    begin
        nx_mag_reg  <= nx_reg[NUMW-1] ? NUMW'(-nx_reg) : NUMW'(nx_reg);
        ny_mag_reg  <= ny_reg[NUMW-1] ? NUMW'(-ny_reg) : NUMW'(ny_reg);
        den_mag_reg <= den_neg ? DENW'(-den6_reg) : DENW'(den6_reg);
        neg_x_reg   <= nx_reg[NUMW-1] ^ den_neg;
        neg_y_reg   <= ny_reg[NUMW-1] ^ den_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= valid_in;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    assign valid_out = v7_reg;
    assign num_x_mag = nx_mag_reg;
    assign num_y_mag = ny_mag_reg;
    assign den_mag   = den_mag_reg;
    assign neg_x     = neg_x_reg;
    assign neg_y     = neg_y_reg;

endmodule

>>> rtl/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with range overflow flag.
module sgi_div #(
    parameter int COORD_BITS = sgi_pkg::SGI_COORD_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic [3*COORD_BITS+5:0] num_mag,
    input  logic [2*COORD_BITS+4:0] den_mag,
    input  logic                    neg_in,
    output logic                    valid_out,
    output logic [COORD_BITS-1:0]   quo_mag,
    output logic                    ovf,
    output logic                    neg_out
);
    import sgi_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int NUMW = 3 * N + 6;
    localparam int DENW = 2 * N + 5;
    localparam int SW   = NUMW + 1;

    logic [NUMW-1:0] rem_reg [N];
    logic [DENW-1:0] d_reg   [N];
    logic [N-1:0]    q_reg   [N];
    logic            ovf_reg [N];
    logic            neg_reg [N];
    logic            v_reg   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam int B = N - 1 - k;
        logic [NUMW-1:0] rem_in;
        logic [DENW-1:0] d_in;
        logic [N-1:0]    q_in;
        logic            ovf_in;
        logic            neg_i;
        logic            v_in;
        logic [SW:0]     trial;

        if (k == 0)
        begin : g_first
            // A quotient of 2**N or more is out of range; a zero divisor lands here too.
            assign ovf_in = ({1'b0, num_mag} >= ((SW)'(den_mag) << N));
            assign rem_in = num_mag;
            assign d_in   = den_mag;
            assign q_in   = '0;
            assign neg_i  = neg_in;
            assign v_in   = valid_in;
        end
        else
        begin : g_next
            assign ovf_in = ovf_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign neg_i  = neg_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        assign trial = (SW+1)'(rem_in) - ((SW+1)'(d_in) << B);

        always_ff @(posedge clk)
        begin
            if (!trial[SW])
            begin
                rem_reg[k] <= NUMW'(trial);
                q_reg[k]   <= q_in | (N'(1) << B);
            end
            else
            begin
                rem_reg[k] <= rem_in;
                q_reg[k]   <= q_in;
            end
            d_reg[k]   <= d_in;
            ovf_reg[k] <= ovf_in;
            neg_reg[k] <= neg_i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in;
            end
        end
    end

    assign valid_out = v_reg[N-1];
    assign quo_mag   = q_reg[N-1];
    assign ovf       = ovf_reg[N-1];
    assign neg_out   = neg_reg[N-1];

endmodule
